>>> rtl/trig_pkg.sv
// ----------------------------------------------------------------------------
// TLB range invalidate generator package
// Shared types, command codes and the scale helpers used by the generator.
// ----------------------------------------------------------------------------
package trig_pkg;

    localparam int OPERAND_W   = 47;
    localparam int PAGE_FIELD_W = 44;
    localparam int RANGE_BASE_W = 37;
    localparam int PAGE_SHIFT  = 12;
    localparam int RESULT_CAP  = 64;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAGE  = 2'd0;
    localparam kind_t KIND_RANGE = 2'd1;
    localparam kind_t KIND_ALL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIZE,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_PAGE,
        MODE_RANGE,
        MODE_ALL
    } mode_t;

    typedef enum logic [1:0] {
        SCALE_0,
        SCALE_1,
        SCALE_2,
        SCALE_3
    } scale_t;

    typedef struct packed {
        mode_t                     mode;
        logic [PAGE_FIELD_W-1:0]   page;
        logic [5:0]                units;
        scale_t                    scale;
        logic [1:0]                level;
        logic                      range_ok;
    } cmd_t;

    // Size of one scale unit, as a shift of the page number.
    function automatic logic [4:0] scale_shift(input scale_t scale);
        logic [4:0] sh;
        begin
            case (scale)
                SCALE_0: sh = 5'd1;
                SCALE_1: sh = 5'd6;
                SCALE_2: sh = 5'd11;
                SCALE_3: sh = 5'd16;
                default: sh = 5'd1;
            endcase
            return sh;
        end
    endfunction

    function automatic scale_t pick_scale(input logic [31:0] pages);
        scale_t sc;
        begin
            if (pages <= 32'd64) begin
                sc = SCALE_0;
            end else if (pages <= 32'h800) begin
                sc = SCALE_1;
            end else if (pages <= 32'h10000) begin
                sc = SCALE_2;
            end else begin
                sc = SCALE_3;
            end
            return sc;
        end
    endfunction

endpackage

>>> rtl/trig_fmt.sv
// ----------------------------------------------------------------------------
// TLB invalidate operand formatter
// Encodes one command descriptor into the invalidation operand and its kind.
// ----------------------------------------------------------------------------
module trig_fmt (
    input  trig_pkg::cmd_t                        cmd,
    output logic [trig_pkg::OPERAND_W-1:0]        operand,
    output trig_pkg::kind_t                       kind
);
    import trig_pkg::*;

    logic [4:0] units_m1;

    assign units_m1 = 5'(cmd.units - 6'd1);

    always_comb
    begin
        operand = '0;
        kind    = KIND_ALL;
        case (cmd.mode)
            MODE_PAGE:
            begin
                kind = KIND_PAGE;
                operand[PAGE_FIELD_W-1:0] = cmd.page;
                if (cmd.range_ok && (cmd.level != 2'd0)) begin
                    operand[46:44] = {1'b1, cmd.level};
                end
            end
            MODE_RANGE:
            begin
                kind = KIND_RANGE;
                operand[RANGE_BASE_W-1:0] = cmd.page[RANGE_BASE_W-1:0];
                operand[38:37] = cmd.level;
                operand[43:39] = units_m1;
                operand[45:44] = cmd.scale;
                operand[46]    = 1'b1;
            end
            MODE_ALL:
            begin
                kind    = KIND_ALL;
                operand = '0;
            end
            default:
            begin
                kind    = KIND_ALL;
                operand = '0;
            end
        endcase
    end

endmodule

>>> rtl/tlb_range_invalidate_generator_unit.sv
// ----------------------------------------------------------------------------
// TLB range invalidate generator
// Turns a page-aligned virtual range into a list of TLB invalidation commands.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; start_addr, end_addr,
// range_ok and table_level are sampled on that edge. busy then stays high
// until the request's last command has been formed.
// Each command is presented on tlbi_operand, command_kind and last_command for
// exactly one cycle with result_valid high; last_command marks the final beat.
// The receiver cannot stall, so beats are simply issued one per cycle.
// Flow: after the accepting edge the request is sized (ST_SIZE) and planned
// (ST_PLAN); each command is then formed in ST_EMIT and captured by the
// output register, which holds it for the beat. After the first beat one beat
// follows per cycle until last_command. busy stays high until ST_EMIT ends,
// so the next request is taken only after the current one is through; an
// empty range gives no beat and returns to idle straight from sizing.
// The sequencer's single cursor adder and remaining-units subtractor advance
// by one command per cycle.
// Reset clears the sequencer and the strobe; no command is in flight after it.
// ----------------------------------------------------------------------------
module tlb_range_invalidate_generator_unit #(
    parameter int VA_BITS   = 39,
    parameter int MAX_UNITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [38:0]                            start_addr,
    input  logic [39:0]                            end_addr,
    input  logic                                   range_ok,
    input  logic [1:0]                             table_level,
    output logic                                   result_valid,
    output logic [trig_pkg::OPERAND_W-1:0]         tlbi_operand,
    output trig_pkg::kind_t                        command_kind,
    output logic                                   last_command
);
    import trig_pkg::*;

    localparam int PG_W  = VA_BITS - PAGE_SHIFT + 1;
    localparam logic [39:0] SPACE = 40'(1) << VA_BITS;
    localparam logic [31:0] UNIT_CAP = 32'(RESULT_CAP * MAX_UNITS);
    localparam logic [5:0]  MAX_U = 6'(MAX_UNITS);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    scale_t            scale_reg, scale_next;
    logic [PG_W-1:0]   s_reg, s_next;
    logic [PG_W-1:0]   e_reg, e_next;
    logic [PG_W-1:0]   pages_reg, pages_next;
    logic [PG_W-1:0]   cursor_reg, cursor_next;
    logic [PG_W-1:0]   rem_reg, rem_next;
    logic              range_reg, range_next;
    logic [1:0]        level_reg, level_next;

    logic              valid_reg;
    logic [OPERAND_W-1:0] operand_reg;
    kind_t             kind_reg;
    logic              last_reg;

    logic [39:0]       end_sat;
    logic [PG_W:0]     diff;
    scale_t            plan_scale;
    logic [4:0]        plan_sh;
    logic [PG_W-1:0]   plan_mask;
    logic [PG_W-1:0]   plan_first;
    logic [PG_W:0]     plan_last_sum;
    logic [PG_W-1:0]   plan_last;
    logic [PG_W-1:0]   plan_total;
    logic [4:0]        emit_sh;
    logic [5:0]        units;
    logic              emit_last;
    logic              emitting;
    cmd_t              cmd;
    logic [OPERAND_W-1:0] fmt_operand;
    kind_t             fmt_kind;

    assign end_sat = (end_addr > SPACE) ? SPACE : end_addr;
    assign diff    = {1'b0, e_reg} - {1'b0, s_reg};

    assign plan_scale    = pick_scale(32'(pages_reg));
    assign plan_sh       = scale_shift(plan_scale);
    assign plan_mask     = (PG_W'(1) << plan_sh) - PG_W'(1);
    assign plan_first    = s_reg & ~plan_mask;
    assign plan_last_sum = {1'b0, e_reg} + {1'b0, plan_mask};
    assign plan_last     = plan_last_sum[PG_W-1:0] & ~plan_mask;
    assign plan_total    = (plan_last - plan_first) >> plan_sh;

    assign emit_sh   = (mode_reg == MODE_RANGE) ? scale_shift(scale_reg) : 5'd0;
    assign emitting  = (state_reg == ST_EMIT);
    assign emit_last = (rem_reg == PG_W'(units));

    always_comb
    begin
        if (mode_reg != MODE_RANGE) begin
            units = 6'd1;
        end else if (rem_reg > PG_W'(MAX_U)) begin
            units = MAX_U;
        end else begin
            units = rem_reg[5:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        scale_next  = scale_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        pages_next  = pages_reg;
        cursor_next = cursor_reg;
        rem_next    = rem_reg;
        range_next  = range_reg;
        level_next  = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    s_next     = {1'b0, start_addr[VA_BITS-1:PAGE_SHIFT]};
                    e_next     = end_sat[VA_BITS:PAGE_SHIFT];
                    range_next = range_ok;
                    level_next = table_level;
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                pages_next = diff[PG_W-1:0];
                if (diff[PG_W] || (diff == '0)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                scale_next = plan_scale;
                state_next = ST_EMIT;
                if ((pages_reg <= PG_W'(1)) || (!range_reg && (pages_reg <= PG_W'(8)))) begin
                    mode_next   = MODE_PAGE;
                    cursor_next = s_reg;
                    rem_next    = pages_reg;
                end else if (!range_reg || (32'(plan_total) > UNIT_CAP)) begin
                    mode_next   = MODE_ALL;
                    rem_next    = PG_W'(1);
                end else begin
                    mode_next   = MODE_RANGE;
                    cursor_next = plan_first;
                    rem_next    = plan_total;
                end
            end
            ST_EMIT:
            begin
                cursor_next = cursor_reg + (PG_W'(units) << emit_sh);
                rem_next    = rem_reg - PG_W'(units);
                if (emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.mode     = mode_reg;
        cmd.page     = PAGE_FIELD_W'(cursor_reg);
        cmd.units    = units;
        cmd.scale    = scale_reg;
        cmd.level    = level_reg;
        cmd.range_ok = range_reg;
    end

    assign busy = (state_reg != ST_IDLE);

    trig_fmt u_fmt (
        .cmd     (cmd),
        .operand (fmt_operand),
        .kind    (fmt_kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= emitting;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        scale_reg   <= scale_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        pages_reg   <= pages_next;
        cursor_reg  <= cursor_next;
        rem_reg     <= rem_next;
        range_reg   <= range_next;
        level_reg   <= level_next;
        operand_reg <= fmt_operand;
        kind_reg    <= fmt_kind;
        last_reg    <= emit_last;
    end

    assign result_valid = valid_reg;
    assign tlbi_operand = operand_reg;
    assign command_kind = kind_reg;
    assign last_command = last_reg;

endmodule
